// ===== rtl/send_rate_deadline_pacer_defines.svh =====
// Assertion macros shared by the send rate deadline pacer modules.
`ifndef SEND_RATE_DEADLINE_PACER_DEFINES_SVH
`define SEND_RATE_DEADLINE_PACER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SRDP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SRDP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/srdp_pkg.sv =====
// Shared widths, codes and control types for the send rate deadline pacer.
package srdp_pkg;

  localparam int RATE_W        = 24;
  localparam int LEN_W         = 16;
  localparam int PEND_W        = 26;
  localparam int STATUS_W      = 2;
  localparam int TIME_BITS_DEF = 48;
  localparam int CNT_W         = $clog2(PEND_W);

  localparam logic [RATE_W-1:0]   RATE_RESET = RATE_W'(1000);
  localparam logic [9:0]          SCALE_MS   = 10'd1000;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic acc_step;
    logic add_step;
    logic emit;
  } srdp_cmd_t;

  typedef struct packed {
    logic tick;
    logic pend_nz;
  } srdp_stat_t;

endpackage

// ===== rtl/srdp_if.sv =====
// Request and response channel interfaces for the send rate deadline pacer.
interface srdp_req_if import srdp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [LEN_W-1:0]     send_length;
  logic [TIME_BITS-1:0] prev_deadline_ms;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, action, send_length, prev_deadline_ms, now_ms,
                  input ready);
  modport sink   (input valid, action, send_length, prev_deadline_ms, now_ms,
                  output ready);
endinterface

interface srdp_rsp_if import srdp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 released;
  logic [TIME_BITS-1:0] next_deadline_ms;

  modport source (output valid, status, released, next_deadline_ms, input ready);
  modport sink   (input valid, status, released, next_deadline_ms, output ready);
endinterface

// ===== rtl/send_rate_deadline_pacer.sv =====
// Send rate deadline pacer: grants sends and advances deadlines at a byte rate.
// Send request: load, then emit registers the result beat; new accepts only in idle.
// Tick with pending work: result beat after the load, the 26-step bit-serial divider,
//   one remainder update, one add and emit, which waits for the output; then idle.
// Tick without pending work: same timing as a send request.
// Reset (rst, synchronous): rate 1000, pending work and remainder zero, no result.
module send_rate_deadline_pacer import srdp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  srdp_req_if.sink          req,
  srdp_rsp_if.source        rsp,
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data
);

  srdp_cmd_t  cmd;
  srdp_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  srdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srdp_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .action           (req.action),
    .send_length      (req.send_length),
    .prev_deadline_ms (req.prev_deadline_ms),
    .now_ms           (req.now_ms),
    .cmd              (cmd),
    .stat             (stat),
    .status           (rsp.status),
    .released         (rsp.released),
    .next_deadline_ms (rsp.next_deadline_ms)
  );

endmodule

// ===== rtl/srdp_dp.sv =====
// Datapath: rate register, pending work, bit-serial divider, deadline adder.
`include "send_rate_deadline_pacer_defines.svh"

module srdp_dp import srdp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [RATE_W-1:0]    cfg_wr_data,
  input  logic                 action,
  input  logic [LEN_W-1:0]     send_length,
  input  logic [TIME_BITS-1:0] prev_deadline_ms,
  input  logic [TIME_BITS-1:0] now_ms,
  input  srdp_cmd_t            cmd,
  output srdp_stat_t           stat,
  output logic [STATUS_W-1:0]  status,
  output logic                 released,
  output logic [TIME_BITS-1:0] next_deadline_ms
);

  logic [RATE_W-1:0]    rate;
  logic [PEND_W-1:0]    pending;
  logic [RATE_W-1:0]    rem_acc;
  logic [PEND_W-1:0]    quo;
  logic [RATE_W-1:0]    rem;
  logic                 carry;
  logic [TIME_BITS-1:0] base;
  logic [STATUS_W-1:0]  status_r;
  logic                 released_r;

  logic [RATE_W:0]      shifted;
  logic [RATE_W+1:0]    trial;
  logic [RATE_W:0]      acc_sum;
  logic                 acc_ge;
  logic [RATE_W:0]      acc_sub;
  logic [TIME_BITS-1:0] start;

  assign stat.tick    = (action == ACT_TICK);
  assign stat.pend_nz = (pending != '0);

  assign shifted = {rem, quo[PEND_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, rate};
  assign acc_sum = {1'b0, rem_acc} + {1'b0, rem};
  assign acc_ge  = (acc_sum >= {1'b0, rate});
  assign acc_sub = acc_sum - {1'b0, rate};
  assign start   = (prev_deadline_ms == '0) ? now_ms + TIME_BITS'(1) : prev_deadline_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate    <= RATE_RESET;
      pending <= '0;
      rem_acc <= '0;
    end else begin
      if (cfg_wr_en) begin
        rate <= (cfg_wr_data == '0) ? RATE_W'(1) : cfg_wr_data;
      end
      if (cmd.load) begin
        if (stat.tick) begin
          pending <= '0;
        end else if ((RATE_W'(send_length) <= rate) && !stat.pend_nz) begin
          pending <= PEND_W'(send_length) * PEND_W'(SCALE_MS);
        end
      end
      if (cmd.acc_step) begin
        rem_acc <= acc_ge ? acc_sub[RATE_W-1:0] : acc_sum[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo        <= pending;
      rem        <= '0;
      released_r <= stat.tick && stat.pend_nz;
      if (stat.tick) begin
        base     <= start;
        status_r <= ST_OK;
      end else begin
        base <= '0;
        if (RATE_W'(send_length) > rate) begin
          status_r <= ST_TOO_LONG;
        end else if (stat.pend_nz) begin
          status_r <= ST_BUSY;
        end else begin
          status_r <= ST_OK;
        end
      end
    end
    if (cmd.div_step) begin
      if (!trial[RATE_W+1]) begin
        rem <= trial[RATE_W-1:0];
        quo <= {quo[PEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted[RATE_W-1:0];
        quo <= {quo[PEND_W-2:0], 1'b0};
      end
    end
    if (cmd.acc_step) begin
      carry <= acc_ge;
    end
    if (cmd.add_step) begin
      base <= base + TIME_BITS'(quo) + TIME_BITS'(carry);
    end
    if (cmd.emit) begin
      status           <= status_r;
      released         <= released_r;
      next_deadline_ms <= base;
    end
  end

  `SRDP_CHECK(a_tick_clears_pending, (cmd.load && stat.tick) |=> (pending == '0), "tick left pending work")
  `SRDP_CHECK(a_div_rem_below_rate, cmd.div_step |-> (rem < rate), "divider remainder not below rate")

endmodule

// ===== rtl/srdp_ctrl.sv =====
// Controller: sequences accept, serial divide, remainder update, add and result beat.
`include "send_rate_deadline_pacer_defines.svh"

module srdp_ctrl import srdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  srdp_stat_t stat,
  output srdp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PEND_W - 1);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.tick && stat.pend_nz) begin
            state_next = S_DIV;
            cnt_next   = CNT_LAST;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_ACC;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        state_next   = S_ADD;
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `SRDP_CHECK(a_accept_leaves_idle, (in_valid && in_ready) |=> (state != S_IDLE), "accept stayed idle")
  `SRDP_CHECK(a_div_ends_in_acc, (state == S_DIV && cnt == '0) |=> (state == S_ACC), "divide overran")
  `SRDP_CHECK(a_emit_sets_valid, cmd.emit |=> out_valid, "result beat not presented")
  `SRDP_NEVER(a_emit_not_busy_slot, cmd.emit && out_valid && !out_ready, "result beat overwritten")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the send rate deadline pacer: drives sends and ticks, checks every result beat.
`timescale 1ns / 1ps

module testbench;
  import srdp_pkg::*;

  localparam int TB_TIME = TIME_BITS_DEF;

  typedef struct {
    logic               action;
    logic [LEN_W-1:0]   len;
    logic [TB_TIME-1:0] prev;
    logic [TB_TIME-1:0] now;
  } pace_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                released;
    logic [TB_TIME-1:0]  next;
  } pace_rsp_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [RATE_W-1:0] cfg_wr_data;

  srdp_req_if #(.TIME_BITS(TB_TIME)) req_ch ();
  srdp_rsp_if #(.TIME_BITS(TB_TIME)) rsp_ch ();

  send_rate_deadline_pacer #(.TIME_BITS(TB_TIME)) DUT (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [RATE_W-1:0]  rate_reg = RATE_RESET;
  logic [PEND_W-1:0]  pend_work = '0;
  logic [RATE_W-1:0]  rem_acc = '0;
  logic [TB_TIME-1:0] deadline_trail = '0;

  pace_req_t send_tick_queue[$];
  pace_rsp_t pacer_due[$];
  pace_req_t held_item;

  int send_idle_max = 12;
  int recv_idle_max = 12;
  int send_wait;
  int recv_wait;
  int hold_left;
  int hold_seq = 0;
  int hold_seen;
  int queued_cnt = 0;
  int done_cnt = 0;
  int err_cnt = 0;
  int granted_cnt = 0;
  int busy_cnt = 0;
  int too_long_cnt = 0;
  int release_cnt = 0;
  int rate_writes = 0;

  function automatic pace_rsp_t pace_step(pace_req_t r);
    pace_rsp_t         o;
    logic [RATE_W-1:0] eff;
    logic [PEND_W-1:0] q;
    logic [PEND_W-1:0] rm;
    logic [RATE_W:0]   sum;
    o.status = ST_OK;
    o.released = 1'b0;
    o.next = '0;
    eff = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
    if (r.action == ACT_SEND) begin
      if (RATE_W'(r.len) > eff) begin
        o.status = ST_TOO_LONG;
      end else if (pend_work != '0) begin
        o.status = ST_BUSY;
      end else begin
        pend_work = PEND_W'(r.len) * PEND_W'(SCALE_MS);
      end
    end else begin
      o.next = r.prev;
      if (r.prev == '0) o.next = r.now + TB_TIME'(1);
      if (pend_work != '0) begin
        q = pend_work / eff;
        rm = pend_work % eff;
        sum = {1'b0, rem_acc} + rm[RATE_W:0];
        o.next = o.next + TB_TIME'(q);
        if (sum >= eff) begin
          o.next = o.next + TB_TIME'(1);
          sum = sum - eff;
        end
        rem_acc = sum[RATE_W-1:0];
        pend_work = '0;
        o.released = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic logic [TB_TIME-1:0] rand_stamp();
    case ($urandom_range(0, 3))
      0: return TB_TIME'($urandom_range(0, 5000));
      1: return {TB_TIME{1'b1}} - TB_TIME'($urandom_range(0, 5000));
      default: return TB_TIME'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [TB_TIME-1:0] pick_prev();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return rand_stamp();
      default: begin
        deadline_trail = deadline_trail + TB_TIME'($urandom_range(1, 5000));
        return deadline_trail;
      end
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len(bit fit);
    int unsigned top;
    top = (rate_reg == '0) ? 1 : ((rate_reg > 65535) ? 65535 : int'(rate_reg));
    if (!fit) return LEN_W'($urandom);
    if ($urandom_range(0, 9) == 0) return LEN_W'(top);
    return LEN_W'($urandom_range(0, top));
  endfunction

  function automatic void queue_item(logic act, logic [LEN_W-1:0] len,
                                     logic [TB_TIME-1:0] prev, logic [TB_TIME-1:0] now);
    pace_req_t it;
    it.action = act;
    it.len = len;
    it.prev = prev;
    it.now = now;
    send_tick_queue.push_back(it);
    queued_cnt++;
  endfunction

  task automatic drain();
    @(posedge clk);
    while (done_cnt < queued_cnt) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    rate_reg = v;
    rate_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  always @(posedge clk) begin
    pace_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) pacer_due.push_back(pace_step(held_item));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          req_ch.valid <= 1'b0;
        end else if (send_tick_queue.size() != 0) begin
          nxt = send_tick_queue.pop_front();
          held_item <= nxt;
          req_ch.action <= nxt.action;
          req_ch.send_length <= nxt.len;
          req_ch.prev_deadline_ms <= nxt.prev;
          req_ch.now_ms <= nxt.now;
          req_ch.valid <= 1'b1;
          send_wait <= $urandom_range(0, send_idle_max);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pace_rsp_t due;
    int        w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        done_cnt++;
        if (pacer_due.size() == 0) begin
          $error("result beat with nothing due");
          err_cnt++;
        end else begin
          due = pacer_due.pop_front();
          if (rsp_ch.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_ch.status);
            err_cnt++;
          end
          if (rsp_ch.released !== due.released) begin
            $error("released: expected %0d, got %0d", due.released, rsp_ch.released);
            err_cnt++;
          end
          if (rsp_ch.next_deadline_ms !== due.next) begin
            $error("next_deadline_ms: expected %0h, got %0h", due.next,
                   rsp_ch.next_deadline_ms);
            err_cnt++;
          end
          case (due.status)
            ST_BUSY: busy_cnt++;
            ST_TOO_LONG: too_long_cnt++;
            default: granted_cnt++;
          endcase
          if (due.released) release_cnt++;
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen <= hold_seq;
        hold_left <= 400;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        w = $urandom_range(0, recv_idle_max);
        recv_wait <= w;
        rsp_ch.ready <= (w == 0);
      end else if (recv_wait > 1) begin
        recv_wait <= recv_wait - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        recv_wait <= 0;
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [RATE_W-1:0] rate_plan [9];
    int                target;
    int                phase_start;
    int                kind;
    bit                paused;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_SEND;
    req_ch.send_length = '0;
    req_ch.prev_deadline_ms = '0;
    req_ch.now_ms = '0;
    rsp_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_item(ACT_TICK, '0, '0, '0);
    queue_item(ACT_SEND, '0, '0, '0);
    queue_item(ACT_TICK, 16'hFFFF, 48'd5, {TB_TIME{1'b1}});
    queue_item(ACT_SEND, 16'd1001, '0, '0);
    queue_item(ACT_SEND, 16'd1000, '0, '0);
    queue_item(ACT_SEND, 16'd3, '0, '0);
    queue_item(ACT_SEND, 16'hFFFF, '0, '0);
    queue_item(ACT_TICK, '0, '0, {TB_TIME{1'b1}});
    queue_item(ACT_SEND, 16'd999, '0, '0);
    queue_item(ACT_TICK, '0, 48'hFFFF_FFFF_FF00, '0);
    queue_item(ACT_SEND, 16'd7, '0, '0);
    queue_item(ACT_TICK, '0, 48'd1000, '0);
    write_rate({RATE_W{1'b1}});
    queue_item(ACT_SEND, 16'hFFFF, '0, '0);
    queue_item(ACT_TICK, '0, 48'd1, '0);
    queue_item(ACT_SEND, 16'hFFFF, '0, '0);
    queue_item(ACT_TICK, '0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
    write_rate('0);
    queue_item(ACT_SEND, 16'd1, '0, '0);
    queue_item(ACT_SEND, 16'd2, '0, '0);
    queue_item(ACT_SEND, 16'd1, '0, '0);
    queue_item(ACT_TICK, '0, '0, 48'hAAAA_AAAA_AAAA);
    write_rate(RATE_W'(1));
    queue_item(ACT_SEND, 16'd1, '0, '0);
    queue_item(ACT_TICK, 16'h5555, 48'h5555_5555_5555, '0);

    rate_plan = '{RATE_W'(1000), RATE_W'(1), {RATE_W{1'b1}}, RATE_W'(65535),
                  RATE_W'($urandom_range(2, 3000)), RATE_W'($urandom_range(3000, 70000)),
                  RATE_W'($urandom), RATE_W'(0), RATE_W'(7)};
    for (int p = 0; p < 9; p++) begin
      write_rate(rate_plan[p]);
      send_idle_max = (p % 3 == 1) ? 0 : 12;
      recv_idle_max = (p % 4 == 2) ? 0 : 12;
      phase_start = queued_cnt;
      target = queued_cnt + 180;
      paused = 1'b0;
      while (queued_cnt < target) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          queue_item(ACT_SEND, pick_len(1), rand_stamp(), rand_stamp());
          repeat ($urandom_range(0, 2))
            queue_item(ACT_SEND, pick_len($urandom_range(0, 1)), rand_stamp(), rand_stamp());
          queue_item(ACT_TICK, pick_len(0), pick_prev(), rand_stamp());
        end else if (kind <= 7) begin
          queue_item(1'($urandom), LEN_W'($urandom), pick_prev(), rand_stamp());
        end else if (kind == 8) begin
          queue_item(1'($urandom), pick_len(0), pick_prev(), rand_stamp());
        end else begin
          queue_item(ACT_SEND, '0, rand_stamp(), rand_stamp());
          queue_item(ACT_TICK, pick_len(0), pick_prev(), rand_stamp());
        end
        if (p == 4 && !paused && queued_cnt >= phase_start + 90) begin
          drain();
          paused = 1'b1;
        end
      end
      if (p == 2) begin
        @(posedge clk);
        hold_seq <= hold_seq + 1;
      end
    end
    drain();

    if (pacer_due.size() != 0) begin
      $error("%0d results still due at the end", pacer_due.size());
      err_cnt++;
    end
    $display("checked %0d result beats: %0d ok, %0d busy, %0d too long, %0d releases",
             done_cnt, granted_cnt, busy_cnt, too_long_cnt, release_cnt);
    $display("rate register written %0d times, including 0, 1 and full scale", rate_writes);
    if (err_cnt == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

// ===== send_rate_deadline_pacer.f =====
+incdir+rtl
rtl/srdp_pkg.sv
rtl/srdp_if.sv
rtl/srdp_dp.sv
rtl/srdp_ctrl.sv
rtl/send_rate_deadline_pacer.sv
bench/testbench.sv
